/* design/i2cdws_pkg.sv */
package i2cdws_pkg;

    // Masked bus status codes of a two-wire master.
    localparam logic [7:0] StatusMask     = 8'hF8;
    localparam logic [7:0] StatusStart    = 8'h08;
    localparam logic [7:0] StatusRstart   = 8'h10;
    localparam logic [7:0] StatusSlaAck   = 8'h18;
    localparam logic [7:0] StatusSlaNack  = 8'h20;
    localparam logic [7:0] StatusDataAck  = 8'h28;
    localparam logic [7:0] StatusArbLost  = 8'h38;

    // Command bytes for the converter.
    localparam logic [7:0] CmdEeprom = 8'h60;
    localparam logic [7:0] CmdDac    = 8'h40;

    // Reset value of the try limit.
    localparam logic [7:0] TryLimitReset = 8'd10;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        OUT_BUSY    = 2'd0,
        OUT_SUCCESS = 2'd1,
        OUT_FAILED  = 2'd2,
        OUT_GAVE_UP = 2'd3
    } t_outcome;

    typedef enum logic [0:0] {
        KIND_REQUEST = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_START = 9'b000000010,
        PH_ADDR  = 9'b000000100,
        PH_CMD1  = 9'b000001000,
        PH_LO1   = 9'b000010000,
        PH_HI1   = 9'b000100000,
        PH_CMD2  = 9'b001000000,
        PH_LO2   = 9'b010000000,
        PH_HI2   = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  device_address;
        logic [15:0] dac_value;
        logic        eeprom_too;
        logic [7:0]  bus_status;
    } t_item;

    typedef struct packed {
        t_action    action;
        logic [7:0] tx_byte;
        t_outcome   outcome;
        logic       finished;
    } t_result;

endpackage

/* design/i2cdws_req_if.sv */
interface i2cdws_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  device_address;
    logic [15:0] dac_value;
    logic        eeprom_too;
    logic [7:0]  bus_status;

    modport source (
        output valid, kind, device_address, dac_value, eeprom_too, bus_status,
        input  ready
    );
    modport sink (
        input  valid, kind, device_address, dac_value, eeprom_too, bus_status,
        output ready
    );
endinterface

/* design/i2cdws_res_if.sv */
interface i2cdws_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic [1:0] outcome;
    logic       finished;

    modport source (
        output valid, action, tx_byte, outcome, finished,
        input  ready
    );
    modport sink (
        input  valid, action, tx_byte, outcome, finished,
        output ready
    );
endinterface

/* design/i2cdws_cfg_if.sv */
interface i2cdws_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

/* design/i2cdws_fsm.sv */
// Transaction state and the per-item decision. The result is combinational
// from the current state and the item; the state advances when i_step is high.
module i2cdws_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cdws_pkg::t_item   i_item,
    input  logic [7:0]          i_try_limit,
    output i2cdws_pkg::t_result o_result
);

    i2cdws_pkg::t_phase r_phase, n_phase;
    logic [7:0]         r_tries, n_tries;
    logic [7:0]         r_address, n_address;
    logic [15:0]        r_value, n_value;
    logic               r_eeprom, n_eeprom;

    logic [7:0]         w_status;
    logic [7:0]         w_cmd;
    logic [7:0]         w_tries_base;
    logic               w_exhausted;

    assign w_status     = i_item.bus_status & i2cdws_pkg::StatusMask;
    assign w_cmd        = r_eeprom ? i2cdws_pkg::CmdEeprom : i2cdws_pkg::CmdDac;
    assign w_tries_base = (i_item.kind == i2cdws_pkg::KIND_REQUEST) ? 8'd0 : r_tries;
    assign w_exhausted  = (w_tries_base >= i_try_limit);

    // Decide the next bus action and the next state for the current item.
    always_comb begin
        n_phase   = r_phase;
        n_tries   = r_tries;
        n_address = r_address;
        n_value   = r_value;
        n_eeprom  = r_eeprom;
        o_result  = '{action: i2cdws_pkg::ACT_NONE, tx_byte: 8'd0,
                      outcome: i2cdws_pkg::OUT_BUSY, finished: 1'b0};

        // A request latches its fields and always makes a start attempt.
        if (i_item.kind == i2cdws_pkg::KIND_REQUEST) begin
            n_address = i_item.device_address;
            n_value   = i_item.dac_value;
            n_eeprom  = i_item.eeprom_too;
        end

        if (i_item.kind == i2cdws_pkg::KIND_REQUEST ||
            (r_phase == i2cdws_pkg::PH_START &&
             w_status == i2cdws_pkg::StatusArbLost) ||
            (r_phase == i2cdws_pkg::PH_ADDR &&
             (w_status == i2cdws_pkg::StatusSlaNack ||
              w_status == i2cdws_pkg::StatusArbLost))) begin
            // Start attempt, or give up without a stop once tries are used.
            if (w_exhausted) begin
                n_phase  = i2cdws_pkg::PH_IDLE;
                n_tries  = w_tries_base;
                o_result.outcome  = i2cdws_pkg::OUT_GAVE_UP;
                o_result.finished = 1'b1;
            end else begin
                n_phase  = i2cdws_pkg::PH_START;
                n_tries  = w_tries_base + 8'd1;
                o_result.action = i2cdws_pkg::ACT_START;
            end
        end else begin
            case (r_phase)
                i2cdws_pkg::PH_START: begin
                    if (w_status == i2cdws_pkg::StatusStart ||
                        w_status == i2cdws_pkg::StatusRstart) begin
                        n_phase = i2cdws_pkg::PH_ADDR;
                        o_result.action  = i2cdws_pkg::ACT_BYTE;
                        o_result.tx_byte = r_address;
                    end else begin
                        n_phase = i2cdws_pkg::PH_IDLE;
                        o_result.action   = i2cdws_pkg::ACT_STOP;
                        o_result.outcome  = i2cdws_pkg::OUT_FAILED;
                        o_result.finished = 1'b1;
                    end
                end
                i2cdws_pkg::PH_ADDR: begin
                    if (w_status == i2cdws_pkg::StatusSlaAck) begin
                        n_phase = i2cdws_pkg::PH_CMD1;
                        o_result.action  = i2cdws_pkg::ACT_BYTE;
                        o_result.tx_byte = w_cmd;
                    end else begin
                        n_phase = i2cdws_pkg::PH_IDLE;
                        o_result.action   = i2cdws_pkg::ACT_STOP;
                        o_result.outcome  = i2cdws_pkg::OUT_FAILED;
                        o_result.finished = 1'b1;
                    end
                end
                i2cdws_pkg::PH_CMD1, i2cdws_pkg::PH_LO1, i2cdws_pkg::PH_HI1,
                i2cdws_pkg::PH_CMD2, i2cdws_pkg::PH_LO2, i2cdws_pkg::PH_HI2: begin
                    if (w_status != i2cdws_pkg::StatusDataAck) begin
                        n_phase = i2cdws_pkg::PH_IDLE;
                        o_result.action   = i2cdws_pkg::ACT_STOP;
                        o_result.outcome  = i2cdws_pkg::OUT_FAILED;
                        o_result.finished = 1'b1;
                    end else if (r_phase == i2cdws_pkg::PH_HI2) begin
                        n_phase = i2cdws_pkg::PH_IDLE;
                        o_result.action   = i2cdws_pkg::ACT_STOP;
                        o_result.outcome  = i2cdws_pkg::OUT_SUCCESS;
                        o_result.finished = 1'b1;
                    end else begin
                        o_result.action = i2cdws_pkg::ACT_BYTE;
                        // Low byte follows a command, high byte follows low.
                        if (r_phase == i2cdws_pkg::PH_CMD1 ||
                            r_phase == i2cdws_pkg::PH_CMD2) begin
                            o_result.tx_byte = r_value[7:0];
                        end else if (r_phase == i2cdws_pkg::PH_LO1 ||
                                     r_phase == i2cdws_pkg::PH_LO2) begin
                            o_result.tx_byte = r_value[15:8];
                        end else begin
                            o_result.tx_byte = w_cmd;
                        end
                        case (r_phase)
                            i2cdws_pkg::PH_CMD1: n_phase = i2cdws_pkg::PH_LO1;
                            i2cdws_pkg::PH_LO1:  n_phase = i2cdws_pkg::PH_HI1;
                            i2cdws_pkg::PH_HI1:  n_phase = i2cdws_pkg::PH_CMD2;
                            i2cdws_pkg::PH_CMD2: n_phase = i2cdws_pkg::PH_LO2;
                            default:             n_phase = i2cdws_pkg::PH_HI2;
                        endcase
                    end
                end
                default: begin
                    // A status while idle is ignored.
                    n_phase = i2cdws_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cdws_pkg::PH_IDLE;
            r_tries <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tries <= n_tries;
        end
    end

    // Held request fields.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_address <= n_address;
            r_value   <= n_value;
            r_eeprom  <= n_eeprom;
        end
    end

endmodule

/* design/i2c_dac_write_sequencer_core.sv */
// Sequencer for one write transaction to a two-wire DAC: a request transaction
// latches address, value and EEPROM flag and orders a start unless try_limit
// is zero; each following status transaction (masked with 0xF8) gets exactly
// one result naming the next bus action (start, byte, stop or none), the
// transmit byte, the outcome and whether the write is finished. Arbitration
// loss or an address NACK restarts while tries remain below try_limit,
// otherwise the block gives up without a stop. One transaction is accepted
// every cycle while the result side does not stall. An accepted item is held
// in the input register; the decision itself is one combinational step in
// front of the result register, which offers the result. A result that is
// held back stalls the input only once both registers are full. try_limit
// resets to 10 and may be written at any time the block is idle; its port is
// always ready.
module i2c_dac_write_sequencer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cdws_req_if.sink   i_req,
    i2cdws_res_if.source o_res,
    i2cdws_cfg_if.sink   i_cfg
);

    logic                r_in_valid;
    i2cdws_pkg::t_item   r_in_item;
    logic                r_out_valid;
    i2cdws_pkg::t_result r_out_result;
    logic [7:0]          r_try_limit;

    i2cdws_pkg::t_result w_result;
    logic                w_step;
    logic                w_in_take;

    // The item in the input register advances when the result slot is free.
    assign w_step      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_step;
    assign w_in_take   = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // Valid flags and the try limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_try_limit <= i2cdws_pkg::TryLimitReset;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_try_limit <= i_cfg.data;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= '{kind: i_req.kind, device_address: i_req.device_address,
                           dac_value: i_req.dac_value, eeprom_too: i_req.eeprom_too,
                           bus_status: i_req.bus_status};
        end
        if (w_step) begin
            r_out_result <= w_result;
        end
    end

    i2cdws_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (r_in_item),
        .i_try_limit (r_try_limit),
        .o_result    (w_result)
    );

    assign o_res.valid    = r_out_valid;
    assign o_res.action   = r_out_result.action;
    assign o_res.tx_byte  = r_out_result.tx_byte;
    assign o_res.outcome  = r_out_result.outcome;
    assign o_res.finished = r_out_result.finished;

endmodule

/* design/i2cdws_checker.sv */
module i2cdws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_action,
    input logic [7:0] i_tx_byte,
    input logic [1:0] i_outcome,
    input logic       i_finished
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its action, transmit byte and outcome.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_action) && $stable(i_tx_byte) && $stable(i_outcome))
        else $error("result payload changed while stalled");

    // A result finishes the transaction exactly when it carries an outcome.
    a_finish_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_finished == (i_outcome != i2cdws_pkg::OUT_BUSY)))
        else $error("finished flag disagrees with outcome");

    // Only a byte action carries a transmit byte, and it never ends the write.
    a_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_action == i2cdws_pkg::ACT_BYTE) ? !i_finished
                                                            : (i_tx_byte == 8'd0)))
        else $error("transmit byte on a non-byte action");

    // A stop is only ordered as the end of a transaction.
    a_stop_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == i2cdws_pkg::ACT_STOP) |->
            (i_outcome == i2cdws_pkg::OUT_SUCCESS || i_outcome == i2cdws_pkg::OUT_FAILED))
        else $error("stop without success or failure");

endmodule

bind i2c_dac_write_sequencer_core i2cdws_checker u_i2cdws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_action    (o_res.action),
    .i_tx_byte   (o_res.tx_byte),
    .i_outcome   (o_res.outcome),
    .i_finished  (o_res.finished)
);

/* dv/i2cdws_write_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and configuration channels of the DAC write
// sequencer, predicts each result from its own copy of the sequencer state
// and compares every result transaction against the oldest expected one.
module i2cdws_write_checker
    import i2cdws_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    i2cdws_req_if i_req,
    i2cdws_res_if i_res,
    i2cdws_cfg_if i_cfg,
    output int    o_err_count,
    output int    o_pending,
    output int    o_checked,
    output int    o_successes
);

    localparam int MaxReported = 40;

    // Mirror of the sequencer state and its try limit.
    logic [7:0]  try_limit_q;
    t_phase      phase_q;
    logic [7:0]  tries_used_q;
    logic [7:0]  held_addr_q;
    logic [15:0] held_value_q;
    logic        held_eeprom_q;

    t_result expected_results[$];
    int      err_count = 0;
    int      checked = 0;
    int      successes = 0;

    function automatic t_result pack_result(t_action act, logic [7:0] tx, t_outcome oc,
                                            logic fin);
        t_result r;
        r.action   = act;
        r.tx_byte  = tx;
        r.outcome  = oc;
        r.finished = fin;
        return r;
    endfunction

    // A new start while tries remain, otherwise give up without a stop.
    function automatic t_result start_attempt();
        t_result r;
        if (tries_used_q >= try_limit_q) begin
            phase_q = PH_IDLE;
            r = pack_result(ACT_NONE, 8'h00, OUT_GAVE_UP, 1'b1);
        end else begin
            tries_used_q = tries_used_q + 8'd1;
            phase_q = PH_START;
            r = pack_result(ACT_START, 8'h00, OUT_BUSY, 1'b0);
        end
        return r;
    endfunction

    function automatic t_result stop_failed();
        phase_q = PH_IDLE;
        return pack_result(ACT_STOP, 8'h00, OUT_FAILED, 1'b1);
    endfunction

    function automatic t_result send_next(t_phase nxt, logic [7:0] tx);
        phase_q = nxt;
        return pack_result(ACT_BYTE, tx, OUT_BUSY, 1'b0);
    endfunction

    // Advances the mirrored sequencer by one accepted transaction.
    function automatic t_result advance_sequencer(t_item it);
        logic [7:0] st;
        logic [7:0] cmd;
        t_result    r;
        st  = it.bus_status & StatusMask;
        cmd = held_eeprom_q ? CmdEeprom : CmdDac;
        if (it.kind == KIND_REQUEST) begin
            held_addr_q   = it.device_address;
            held_value_q  = it.dac_value;
            held_eeprom_q = it.eeprom_too;
            tries_used_q  = 8'd0;
            r = start_attempt();
        end else begin
            case (phase_q)
                PH_START: begin
                    if (st == StatusArbLost) begin
                        r = start_attempt();
                    end else if (st == StatusStart || st == StatusRstart) begin
                        r = send_next(PH_ADDR, held_addr_q);
                    end else begin
                        r = stop_failed();
                    end
                end
                PH_ADDR: begin
                    if (st == StatusSlaNack || st == StatusArbLost) begin
                        r = start_attempt();
                    end else if (st == StatusSlaAck) begin
                        r = send_next(PH_CMD1, cmd);
                    end else begin
                        r = stop_failed();
                    end
                end
                PH_CMD1, PH_LO1, PH_HI1, PH_CMD2, PH_LO2, PH_HI2: begin
                    if (st != StatusDataAck) begin
                        r = stop_failed();
                    end else begin
                        case (phase_q)
                            PH_CMD1: r = send_next(PH_LO1, held_value_q[7:0]);
                            PH_LO1:  r = send_next(PH_HI1, held_value_q[15:8]);
                            PH_HI1:  r = send_next(PH_CMD2, cmd);
                            PH_CMD2: r = send_next(PH_LO2, held_value_q[7:0]);
                            PH_LO2:  r = send_next(PH_HI2, held_value_q[15:8]);
                            default: begin
                                phase_q = PH_IDLE;
                                r = pack_result(ACT_STOP, 8'h00, OUT_SUCCESS, 1'b1);
                            end
                        endcase
                    end
                end
                default: begin
                    // A status with no transaction running is ignored.
                    phase_q = PH_IDLE;
                    r = pack_result(ACT_NONE, 8'h00, OUT_BUSY, 1'b0);
                end
            endcase
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v) begin
            err_count++;
            if (err_count <= MaxReported) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            end
        end
    endtask

    // Result transactions are checked before a new request transaction is
    // predicted, so a stray result can never match a fresh expectation.
    always @(posedge i_clk) begin
        t_item   seen;
        t_result want;
        if (!i_rst_n) begin
            try_limit_q   = TryLimitReset;
            phase_q       = PH_IDLE;
            tries_used_q  = 8'd0;
            held_addr_q   = 8'd0;
            held_value_q  = 16'd0;
            held_eeprom_q = 1'b0;
            expected_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= MaxReported) begin
                        $error("result transaction with none expected: action %0d tx_byte %0h",
                               i_res.action, i_res.tx_byte);
                    end
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    compare_field("action", 8'(want.action), 8'(i_res.action));
                    compare_field("tx_byte", want.tx_byte, i_res.tx_byte);
                    compare_field("outcome", 8'(want.outcome), 8'(i_res.outcome));
                    compare_field("finished", 8'(want.finished), 8'(i_res.finished));
                    if (want.outcome == OUT_SUCCESS) begin
                        successes++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                try_limit_q = i_cfg.data;
            end
            if (i_req.valid && i_req.ready) begin
                seen.kind           = i_req.kind;
                seen.device_address = i_req.device_address;
                seen.dac_value      = i_req.dac_value;
                seen.eeprom_too     = i_req.eeprom_too;
                seen.bus_status     = i_req.bus_status;
                expected_results.push_back(advance_sequencer(seen));
            end
        end
        o_err_count <= err_count;
        o_pending   <= expected_results.size();
        o_checked   <= checked;
        o_successes <= successes;
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

// Drives write requests and bus status transactions into the DAC write
// sequencer under several try limits, with random gaps and stalls.
module tb;
    import i2cdws_pkg::*;

    localparam int RxHoldCycles  = 100;
    localparam int WatchdogLimit = 2000;
    localparam int ItemsPerPhase = 125;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    i2cdws_req_if req_bus ();
    i2cdws_res_if res_bus ();
    i2cdws_cfg_if cfg_bus ();

    int err_count;
    int pending;
    int checked;
    int successes;

    // Stimulus bookkeeping.
    int cur_limit = TryLimitReset;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int requests = 0;
    int statuses = 0;
    int ignored = 0;
    int settings = 1;

    i2c_dac_write_sequencer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    i2cdws_write_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .i_res       (res_bus),
        .i_cfg       (cfg_bus),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_successes (successes)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // The low three status bits are don't-care, so fill them at random.
    function automatic logic [7:0] noisy(logic [7:0] code);
        return code | {5'b00000, 3'($urandom_range(0, 7))};
    endfunction

    function automatic logic [7:0] junk_status(logic [7:0] good);
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while ((v & StatusMask) == good);
        return v;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid          <= 1'b1;
        req_bus.kind           <= it.kind;
        req_bus.device_address <= it.device_address;
        req_bus.dac_value      <= it.dac_value;
        req_bus.eeprom_too     <= it.eeprom_too;
        req_bus.bus_status     <= it.bus_status;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    task automatic send_request(input logic [7:0] addr, input logic [15:0] val,
                                input logic ee);
        t_item it;
        it.kind           = KIND_REQUEST;
        it.device_address = addr;
        it.dac_value      = val;
        it.eeprom_too     = ee;
        it.bus_status     = 8'($urandom_range(0, 255));
        send_item(it);
        requests++;
    endtask

    task automatic send_status(input logic [7:0] code);
        t_item it;
        it.kind           = KIND_STATUS;
        it.device_address = 8'($urandom_range(0, 255));
        it.dac_value      = 16'($urandom_range(0, 65535));
        it.eeprom_too     = 1'($urandom_range(0, 1));
        it.bus_status     = code;
        send_item(it);
        statuses++;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_try_limit(input logic [7:0] v);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        cur_limit = v;
        settings++;
    endtask

    // One write transaction with random content: mostly the clean path,
    // with retries, faults and the occasional abandoned sequence mixed in.
    task automatic run_write(input int fault_pct, input int retry_pct);
        int tries;
        bit done;
        tries = 0;
        done  = 1'b0;
        send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)));
        while (!done) begin
            if (tries >= cur_limit) begin
                // The sequencer gives up by itself here.
                done = 1'b1;
            end else begin
                tries++;
                if (roll(retry_pct)) begin
                    send_status(noisy(StatusArbLost));
                end else if (roll(fault_pct)) begin
                    send_status(junk_status(StatusStart));
                    done = 1'b1;
                end else begin
                    send_status(noisy(roll(50) ? StatusStart : StatusRstart));
                    if (roll(retry_pct)) begin
                        send_status(noisy(roll(50) ? StatusSlaNack : StatusArbLost));
                    end else if (roll(fault_pct)) begin
                        send_status(junk_status(StatusSlaAck));
                        done = 1'b1;
                    end else begin
                        send_status(noisy(StatusSlaAck));
                        for (int b = 0; b < 6 && !done; b++) begin
                            if (roll(fault_pct)) begin
                                send_status(junk_status(StatusDataAck));
                                done = 1'b1;
                            end else if (roll(2)) begin
                                // Leave it running; the next request drops it.
                                done = 1'b1;
                            end else begin
                                send_status(noisy(StatusDataAck));
                            end
                        end
                        done = 1'b1;
                    end
                end
            end
        end
    endtask

    // Result side: random stalls, quiet stretches and one long hold-off.
    initial begin
        int stall_left;
        stall_left = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                res_bus.ready <= 1'b0;
                repeat (RxHoldCycles) @(negedge i_clk);
            end else if (rx_quiet) begin
                res_bus.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if (roll(25)) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int target;
        int phase_writes;
        logic [7:0] limit;
        req_bus.valid          = 1'b0;
        req_bus.kind           = KIND_REQUEST;
        req_bus.device_address = 8'd0;
        req_bus.dac_value      = 16'd0;
        req_bus.eeprom_too     = 1'b0;
        req_bus.bus_status     = 8'd0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.data           = 8'd0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset try limit.
        // A status while idle is ignored.
        send_status(StatusDataAck);
        ignored++;
        // Clean write with all-ones fields and the EEPROM command.
        send_request(8'hFF, 16'hFFFF, 1'b1);
        send_status(8'h0F);
        send_status(StatusSlaAck);
        repeat (5) send_status(StatusDataAck);
        send_status(8'h2F);
        // All-zero fields; retries after start and after the address, then
        // an unexpected data status ends in a stop.
        send_request(8'h00, 16'h0000, 1'b0);
        send_status(StatusArbLost);
        send_status(StatusRstart);
        send_status(StatusSlaNack);
        send_status(StatusStart);
        send_status(StatusSlaAck);
        send_status(StatusDataAck);
        send_status(8'h30);
        // A request while busy drops the running transaction.
        send_request(8'hA5, 16'h5AC3, 1'b1);
        send_status(StatusStart);
        send_request(8'h3C, 16'h1234, 1'b0);
        send_status(StatusStart);
        send_status(8'hFF);
        drain_results();

        // A try limit of zero gives up at once.
        write_try_limit(8'd0);
        send_request(8'h5A, 16'hA55A, 1'b0);
        drain_results();

        // With one try, an address NACK gives up; the next status is idle.
        write_try_limit(8'd1);
        send_request(8'hC3, 16'h0FF0, 1'b1);
        send_status(StatusStart);
        send_status(StatusSlaNack);
        send_status(StatusSlaAck);
        ignored++;

        // Random part, one try-limit setting per phase.
        for (int p = 0; p < 8; p++) begin
            drain_results();
            case (p)
                0, 6:    limit = 8'd1;
                1, 5:    limit = 8'd255;
                2:       limit = 8'd2;
                4:       limit = 8'd3;
                default: limit = 8'($urandom_range(1, 255));
            endcase
            write_try_limit(limit);
            tx_quiet = (p == 5);
            rx_quiet = (p == 5);
            if (p == 2) begin
                // Back-to-back offers while the result side holds off.
                hold_requests++;
                tx_quiet = 1'b1;
            end
            target = requests + statuses - ignored + ItemsPerPhase;
            phase_writes = 0;
            while (requests + statuses - ignored < target) begin
                run_write(p == 4 ? 20 : 5, 15);
                phase_writes++;
                if (p == 2 && phase_writes == 6) begin
                    tx_quiet = 1'b0;
                end
                if (roll(10)) begin
                    send_status(8'($urandom_range(0, 255)));
                    ignored++;
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests and %0d bus status transactions under %0d try limits.",
                 requests, statuses, settings);
        $display("Checked %0d results, %0d of them completed writes.", checked, successes);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/i2cdws_pkg.sv
design/i2cdws_req_if.sv
design/i2cdws_res_if.sv
design/i2cdws_cfg_if.sv
design/i2cdws_fsm.sv
design/i2c_dac_write_sequencer_core.sv
design/i2cdws_checker.sv
dv/i2cdws_write_checker.sv
dv/tb.sv
